### hdl/slpm_pkg.sv
// Package for the symmetric layer-pair matrix unit.
// Holds sizes, request codes and the row-store request struct.
// No dependencies.
package slpm_pkg;

  localparam int LAYERS = 64;
  localparam int AW     = $clog2(LAYERS);
  localparam int IDX_W  = 7;
  localparam int MASK_W = 64;

  localparam logic [IDX_W-1:0] LAYER_LIM = IDX_W'(LAYERS);

  localparam logic [2:0] ACT_READ  = 3'd0;
  localparam logic [2:0] ACT_SYM   = 3'd1;
  localparam logic [2:0] ACT_SET   = 3'd2;
  localparam logic [2:0] ACT_APPLY = 3'd3;
  localparam logic [2:0] ACT_MATCH = 3'd4;

  typedef struct packed {
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [LAYERS-1:0] wr_data;
  } mem_req_t;

endpackage

### hdl/slpm_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module slpm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

### hdl/slpm_store.sv
// Row store: the pair-row RAM plus per-row written flags, so rows read as zero after reset.
// Depends on slpm_pkg and slpm_ram.
module slpm_store (
  input  logic                      clk,
  input  logic                      rst,
  input  slpm_pkg::mem_req_t        req,
  output logic [slpm_pkg::LAYERS-1:0] rd_row
);
  import slpm_pkg::*;

  logic [LAYERS-1:0] vld;
  logic              rd_vld;
  logic [LAYERS-1:0] ram_q;

  slpm_ram #(
    .DEPTH(LAYERS),
    .WIDTH(LAYERS)
  ) u_ram (
    .clk  (clk),
    .we   (req.wr_en),
    .waddr(req.wr_addr),
    .wdata(req.wr_data),
    .re   (req.rd_en),
    .raddr(req.rd_addr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.rd_en) begin
        rd_vld <= vld[req.rd_addr];
      end
      if (req.wr_en) begin
        vld[req.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_row = rd_vld ? ram_q : '0;

endmodule

### hdl/symmetric_layer_pair_matrix_unit.sv
// Top level of the symmetric layer-pair matrix unit: request sequencer and result register.
// Depends on slpm_pkg and slpm_store.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------------
//   request  | in_valid / in_ready  | action, first_layer, second_layer, pair_on, layer_mask
//   result   | out_valid / out_ready| ok, answer
//
// Read pair: PAIR_A, FINISH. Symmetry check, set pair: PAIR_A, PAIR_B, FINISH. Apply mask,
// match mask: WALK, one row per cycle through the single RAM read port. Bad index: FINISH.
// Reset clears all rows at once through per-row written flags; no clearing pass.
// A new item is taken while the previous result waits; a stalled result holds the
// sequencer in its final state until the result register frees.
module symmetric_layer_pair_matrix_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  action,
  input  logic [slpm_pkg::IDX_W-1:0]  first_layer,
  input  logic [slpm_pkg::IDX_W-1:0]  second_layer,
  input  logic                        pair_on,
  input  logic [slpm_pkg::MASK_W-1:0] layer_mask,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        ok,
  output logic                        answer
);
  import slpm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAIR_A,
    S_PAIR_B,
    S_WALK,
    S_FINISH
  } state_t;

  state_t            state;
  logic [2:0]        act_r;
  logic [AW-1:0]     a_r;
  logic [AW-1:0]     b_r;
  logic              on_r;
  logic [LAYERS-1:0] mask_r;
  logic [AW-1:0]     k;
  logic              match;
  logic              pair_ab;
  logic              res_ok;
  logic              res_ans;

  mem_req_t          req;
  logic [LAYERS-1:0] rd_row;
  logic              a_ok;
  logic              b_ok;
  logic              go_pair;
  logic              go_walk;
  logic              k_last;
  logic              k_miss;

  slpm_store u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rd_row(rd_row)
  );

  assign in_ready = (state == S_IDLE);
  assign a_ok     = (first_layer < LAYER_LIM);
  assign b_ok     = (second_layer < LAYER_LIM);
  assign go_pair  = (action inside {ACT_READ, ACT_SYM, ACT_SET}) && a_ok && b_ok;
  assign go_walk  = (action inside {ACT_APPLY, ACT_MATCH}) && a_ok;
  assign k_last   = (k == AW'(LAYERS - 1));
  assign k_miss   = (rd_row[a_r] != mask_r[k]) || ((k == a_r) && (rd_row != mask_r));

  always_comb begin
    logic [LAYERS-1:0] row_mod;
    row_mod = rd_row;
    req     = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && (go_pair || go_walk)) begin
          req.rd_en   = 1'b1;
          req.rd_addr = go_walk ? '0 : first_layer[AW-1:0];
        end
      end
      S_PAIR_A: begin
        if (act_r == ACT_SYM || act_r == ACT_SET) begin
          req.rd_en   = 1'b1;
          req.rd_addr = b_r;
        end
        if (act_r == ACT_SET) begin
          row_mod[b_r] = on_r;
          req.wr_en    = 1'b1;
          req.wr_addr  = a_r;
          req.wr_data  = row_mod;
        end
      end
      S_PAIR_B: begin
        if (act_r == ACT_SET) begin
          row_mod[a_r] = on_r;
          req.wr_en    = 1'b1;
          req.wr_addr  = b_r;
          req.wr_data  = row_mod;
        end
      end
      S_WALK: begin
        if (!k_last) begin
          req.rd_en   = 1'b1;
          req.rd_addr = k + AW'(1);
        end
        if (act_r == ACT_APPLY) begin
          row_mod[a_r] = mask_r[k];
          req.wr_en    = 1'b1;
          req.wr_addr  = k;
          req.wr_data  = (k == a_r) ? mask_r : row_mod;
        end
      end
      S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act_r   <= action;
            a_r     <= first_layer[AW-1:0];
            b_r     <= second_layer[AW-1:0];
            on_r    <= pair_on;
            mask_r  <= layer_mask[LAYERS-1:0];
            k       <= '0;
            match   <= 1'b1;
            res_ok  <= 1'b0;
            res_ans <= 1'b0;
            if (go_pair) begin
              state <= S_PAIR_A;
            end else if (go_walk) begin
              state <= S_WALK;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_PAIR_A: begin
          res_ok  <= 1'b1;
          pair_ab <= rd_row[b_r];
          if (act_r == ACT_READ) begin
            res_ans <= rd_row[b_r];
            state   <= S_FINISH;
          end else begin
            state   <= S_PAIR_B;
          end
        end
        S_PAIR_B: begin
          res_ans <= (act_r == ACT_SYM) && (pair_ab == rd_row[a_r]);
          state   <= S_FINISH;
        end
        S_WALK: begin
          res_ok <= 1'b1;
          k      <= k + AW'(1);
          if (k_miss) begin
            match <= 1'b0;
          end
          if (k_last) begin
            res_ans <= (act_r == ACT_MATCH) && match && !k_miss;
            state   <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            ok        <= res_ok;
            answer    <= res_ans;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    req.wr_en |-> (state == S_PAIR_A || state == S_PAIR_B || state == S_WALK))
    else $error("row write outside a request");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result loaded outside final state");

  a_walk_runs: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && !k_last) |=> (state == S_WALK))
    else $error("row walk cut short");

  a_fail_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> !answer)
    else $error("failed request with answer set");

endmodule
